### hdl/crr_pkg.sv
// Shared types and constants of the chunk reassembly ring controller.
package crr_pkg;

  localparam int unsigned HEADER_BYTES = 16;
  localparam logic [31:0] NO_FRAME     = 32'hFFFF_FFFF;

  // Chunk map is stored in rows of this many bits.
  localparam int unsigned ROW_BITS  = 16;
  localparam int unsigned ROW_SHIFT = 4;

  localparam int unsigned CNT_W = 11;  // chunk totals stay below chunk_limit

  localparam logic [15:0] RST_MAGIC_WORD  = 16'h55AA;
  localparam logic [15:0] RST_INPUT_KIND  = 16'd1;
  localparam logic [15:0] RST_CHUNK_BYTES = 16'd1400;
  localparam logic [24:0] RST_FRAME_BYTES = 25'd230400;
  localparam logic [10:0] RST_CHUNK_LIMIT = 11'd700;

  typedef enum logic [2:0] {
    CFG_MAGIC_WORD  = 3'd0,
    CFG_INPUT_KIND  = 3'd1,
    CFG_CHUNK_BYTES = 3'd2,
    CFG_FRAME_BYTES = 3'd3,
    CFG_CHUNK_LIMIT = 3'd4
  } crr_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_WRITTEN   = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_BAD_TOTAL = 3'd3,
    ST_RING_FULL = 3'd4,
    ST_OUTSIDE   = 3'd5,
    ST_POPPED    = 3'd6,
    ST_POP_EMPTY = 3'd7
  } crr_status_e;

  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_POP    = 1'b1
  } crr_op_e;

  // Input tdata, last field in the lowest bits.
  typedef struct packed {
    logic [15:0] payload_length;
    logic [15:0] chunk_total;
    logic [15:0] chunk_index;
    logic [31:0] frame_id;
    logic [15:0] kind;
    logic [15:0] magic;
    logic [15:0] packet_length;
  } crr_hdr_t;

  // Output tdata, last field in the lowest bits.
  typedef struct packed {
    logic        pad;
    logic [6:0]  frames_ready;
    logic [5:0]  head_slot;
    logic        head_valid;
    logic        frame_done;
    logic [15:0] write_length;
    logic [24:0] write_offset;
    logic [5:0]  write_slot;
    logic        write_enable;
  } crr_res_t;

endpackage

### hdl/crr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module crr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/chunk_reassembly_ring_unit.sv
// Chunk reassembly ring controller: top level.
// An accepted item is held in the input register, its result in the result register;
// stalls on the result side hold both. Throughput: one item per cycle unless the result
// side stalls, set by the chunk map row read-modify-write (map RAM read at accept, written
// on leaving the input register; a forwarding register covers back-to-back rows).
// Reset: control state, ring pointers and config registers return to defaults at once;
// chunk map rows are guarded by per-row valid flops, so there is no clearing pass.
module chunk_reassembly_ring_unit #(
  parameter int unsigned SLOTS          = 64,
  parameter int unsigned CHUNK_MAP_BITS = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // config write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [24:0]  cfg_data_i,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // packet_length[15:0], magic[31:16], kind[47:32], frame_id[79:48],
  // chunk_index[95:80], chunk_total[111:96], payload_length[127:112]
  input  logic [127:0] s_axis_tdata,
  // op[0]
  input  logic         s_axis_tuser,
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // write_enable[0], write_slot[6:1], write_offset[31:7], write_length[47:32],
  // frame_done[48], head_valid[49], head_slot[55:50], frames_ready[62:56], zero[63]
  output logic [63:0]  m_axis_tdata,
  // status[2:0]
  output logic [2:0]   m_axis_tuser
);

  localparam int unsigned POS_W  = $clog2(SLOTS);
  localparam int unsigned RDY_W  = $clog2(SLOTS + 1);
  localparam int unsigned ROWS   = (CHUNK_MAP_BITS + crr_pkg::ROW_BITS - 1) / crr_pkg::ROW_BITS;
  localparam int unsigned ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned BIT_W  = crr_pkg::ROW_SHIFT;

  // config registers
  logic [15:0] magic_word_q, input_kind_q, chunk_bytes_q;
  logic [24:0] frame_bytes_q;
  logic [10:0] chunk_limit_q;

  // input stage
  logic              s1_valid_q;
  crr_pkg::crr_hdr_t s1_hdr_q;
  logic              s1_op_q;
  logic              s1_fire, in_accept;

  // frame and ring state
  logic                     open_q, open_d;
  logic [31:0]              open_num_q, open_num_d;
  logic [crr_pkg::CNT_W-1:0] exp_q, exp_d, recv_q, recv_d;
  logic [ROWS-1:0]          row_valid_q, row_valid_d;
  logic [POS_W-1:0]         wr_pos_q, wr_pos_d, rd_pos_q, rd_pos_d;
  logic [RDY_W-1:0]         ready_q, ready_d;

  // chunk map RAM and forwarding
  logic                        map_we;
  logic [ROW_AW-1:0]           map_waddr, map_raddr;
  logic [crr_pkg::ROW_BITS-1:0] map_wdata, map_rdata;
  logic                        byp_hit_q;
  logic [crr_pkg::ROW_BITS-1:0] byp_data_q;
  crr_pkg::crr_hdr_t           in_hdr;

  // result register
  logic              out_valid_q;
  crr_pkg::crr_res_t res_q, res_d;
  crr_pkg::crr_status_e status_q, status_d;

  // step logic
  logic                         new_frame, in_range, seen, done;
  logic [crr_pkg::CNT_W-1:0]    exp_sel, recv_base, recv_new;
  logic [31:0]                  offset;
  logic [32:0]                  end_byte;
  logic [ROW_AW-1:0]            row;
  logic [crr_pkg::ROW_BITS-1:0] row_data;

  assign cfg_ready_o   = 1'b1;
  assign s1_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_hdr        = crr_pkg::crr_hdr_t'(s_axis_tdata);
  assign map_raddr     = ROW_AW'(in_hdr.chunk_index >> crr_pkg::ROW_SHIFT);

  crr_ram #(
    .WIDTH (crr_pkg::ROW_BITS),
    .DEPTH (ROWS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (in_accept),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_word_q  <= crr_pkg::RST_MAGIC_WORD;
      input_kind_q  <= crr_pkg::RST_INPUT_KIND;
      chunk_bytes_q <= crr_pkg::RST_CHUNK_BYTES;
      frame_bytes_q <= crr_pkg::RST_FRAME_BYTES;
      chunk_limit_q <= crr_pkg::RST_CHUNK_LIMIT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        crr_pkg::CFG_MAGIC_WORD:  magic_word_q  <= cfg_data_i[15:0];
        crr_pkg::CFG_INPUT_KIND:  input_kind_q  <= cfg_data_i[15:0];
        crr_pkg::CFG_CHUNK_BYTES: chunk_bytes_q <= cfg_data_i[15:0];
        crr_pkg::CFG_FRAME_BYTES: frame_bytes_q <= cfg_data_i;
        crr_pkg::CFG_CHUNK_LIMIT: chunk_limit_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    new_frame   = !open_q || (s1_hdr_q.frame_id != open_num_q);
    exp_sel     = new_frame ? s1_hdr_q.chunk_total[crr_pkg::CNT_W-1:0] : exp_q;
    recv_base   = new_frame ? '0 : recv_q;
    offset      = {16'b0, s1_hdr_q.chunk_index} * {16'b0, chunk_bytes_q};
    end_byte    = {1'b0, offset} + 33'(s1_hdr_q.payload_length);
    in_range    = (s1_hdr_q.chunk_index < {5'b0, exp_sel})
               && (s1_hdr_q.chunk_index < 16'(CHUNK_MAP_BITS))
               && (end_byte <= 33'(frame_bytes_q));
    row         = ROW_AW'(s1_hdr_q.chunk_index >> crr_pkg::ROW_SHIFT);
    // a row not touched since the last map clear reads as empty
    if (new_frame || !row_valid_q[row]) begin
      row_data = '0;
    end else if (byp_hit_q) begin
      row_data = byp_data_q;
    end else begin
      row_data = map_rdata;
    end
    seen        = row_data[s1_hdr_q.chunk_index[BIT_W-1:0]];
    recv_new    = recv_base + crr_pkg::CNT_W'(!seen);
    done        = 1'b0;

    open_d      = open_q;
    open_num_d  = open_num_q;
    exp_d       = exp_q;
    recv_d      = recv_q;
    row_valid_d = row_valid_q;
    wr_pos_d    = wr_pos_q;
    rd_pos_d    = rd_pos_q;
    ready_d     = ready_q;
    map_we      = 1'b0;
    map_waddr   = row;
    map_wdata   = row_data | (crr_pkg::ROW_BITS'(1) << s1_hdr_q.chunk_index[BIT_W-1:0]);
    status_d    = crr_pkg::ST_POP_EMPTY;
    res_d       = '0;

    if (s1_op_q == crr_pkg::OP_POP) begin
      if (ready_q != '0) begin
        status_d = crr_pkg::ST_POPPED;
        rd_pos_d = (rd_pos_q == POS_W'(SLOTS - 1)) ? '0 : rd_pos_q + 1'b1;
        ready_d  = ready_q - 1'b1;
      end
    end else if (s1_hdr_q.packet_length < 16'(crr_pkg::HEADER_BYTES)) begin
      status_d = crr_pkg::ST_SHORT;
    end else if (s1_hdr_q.magic != magic_word_q || s1_hdr_q.kind != input_kind_q) begin
      status_d = crr_pkg::ST_BAD_MAGIC;
    end else if (s1_hdr_q.chunk_total == '0 ||
                 s1_hdr_q.chunk_total >= {5'b0, chunk_limit_q}) begin
      status_d = crr_pkg::ST_BAD_TOTAL;
    end else if (!open_q && ready_q >= RDY_W'(SLOTS)) begin
      status_d = crr_pkg::ST_RING_FULL;
    end else begin
      if (new_frame) begin
        open_d      = 1'b1;
        open_num_d  = s1_hdr_q.frame_id;
        exp_d       = exp_sel;
        recv_d      = '0;
        row_valid_d = '0;
      end
      if (in_range) begin
        status_d           = crr_pkg::ST_WRITTEN;
        res_d.write_enable = 1'b1;
        res_d.write_slot   = 6'(wr_pos_q);
        res_d.write_offset = offset[24:0];
        res_d.write_length = s1_hdr_q.payload_length;
        recv_d             = recv_new;
        if (!seen) begin
          map_we           = 1'b1;
          row_valid_d[row] = 1'b1;
        end
        if (recv_new == exp_sel) begin
          done        = 1'b1;
          ready_d     = ready_q + 1'b1;
          wr_pos_d    = (wr_pos_q == POS_W'(SLOTS - 1)) ? '0 : wr_pos_q + 1'b1;
          open_d      = 1'b0;
          open_num_d  = crr_pkg::NO_FRAME;
          exp_d       = '0;
          recv_d      = '0;
          row_valid_d = '0;
        end
      end else begin
        status_d = crr_pkg::ST_OUTSIDE;
      end
    end

    res_d.frame_done   = done;
    res_d.head_valid   = (ready_d != '0);
    res_d.head_slot    = 6'(rd_pos_d);
    res_d.frames_ready = 7'(ready_d);

    if (!s1_fire) begin
      map_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      open_q      <= 1'b0;
      open_num_q  <= crr_pkg::NO_FRAME;
      exp_q       <= '0;
      recv_q      <= '0;
      row_valid_q <= '0;
      wr_pos_q    <= '0;
      rd_pos_q    <= '0;
      ready_q     <= '0;
      byp_hit_q   <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        open_q      <= open_d;
        open_num_q  <= open_num_d;
        exp_q       <= exp_d;
        recv_q      <= recv_d;
        row_valid_q <= row_valid_d;
        wr_pos_q    <= wr_pos_d;
        rd_pos_q    <= rd_pos_d;
        ready_q     <= ready_d;
      end
      // RAM returns the old row when read and written in the same cycle
      if (in_accept) begin
        byp_hit_q <= map_we && (map_waddr == map_raddr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_hdr_q   <= in_hdr;
      s1_op_q    <= s_axis_tuser;
      byp_data_q <= map_wdata;
    end
    if (s1_fire) begin
      res_q    <= res_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = status_q;

  a_ready_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q <= RDY_W'(SLOTS))
    else $error("frame count exceeds ring size");

  a_open_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (recv_q < exp_q))
    else $error("open frame holds all of its chunks");

  a_closed_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (recv_q == '0 && exp_q == '0 && row_valid_q == '0))
    else $error("closed frame left chunk state behind");

  a_done_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.frame_done) |->
      (status_q == crr_pkg::ST_WRITTEN && res_q.write_enable))
    else $error("frame posted by a chunk that was not written");

endmodule

### tb/chunk_reassembly_ring_unit_tb.sv
// Self-checking testbench for the chunk reassembly ring controller.
`timescale 1ns / 1ps

module chunk_reassembly_ring_unit_tb;
  import crr_pkg::*;

  localparam int unsigned RING_SLOTS     = 64;
  localparam int unsigned MAP_BITS       = 1024;
  localparam int unsigned RX_HOLD_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT    = 400000;

  typedef struct {
    crr_status_e status;
    crr_res_t    res;
  } frame_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [24:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  // register shadow
  logic [15:0] cfg_magic;
  logic [15:0] cfg_kind;
  logic [15:0] cfg_chunk_bytes;
  logic [24:0] cfg_frame_bytes;
  logic [10:0] cfg_limit;

  // reassembly state shadow
  logic                  frame_open;
  logic [31:0]           open_id;
  logic [15:0]           exp_chunks;
  logic [15:0]           got_chunks;
  logic [MAP_BITS-1:0]   seen_map;
  logic [RING_SLOTS-1:0] slot_ready;
  logic [5:0]            wr_pos;
  logic [5:0]            rd_pos;
  logic [6:0]            ready_cnt;

  frame_result_t pending_results[$];
  int            fails;
  bit            no_idle;
  bit            hold_rx_req;
  int            cycle_count;

  chunk_reassembly_ring_unit #(
    .SLOTS         (RING_SLOTS),
    .CHUNK_MAP_BITS(MAP_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  task automatic close_frame();
    frame_open = 1'b0;
    open_id    = NO_FRAME;
    exp_chunks = '0;
    got_chunks = '0;
    seen_map   = '0;
  endtask

  task automatic model_reset();
    cfg_magic       = RST_MAGIC_WORD;
    cfg_kind        = RST_INPUT_KIND;
    cfg_chunk_bytes = RST_CHUNK_BYTES;
    cfg_frame_bytes = RST_FRAME_BYTES;
    cfg_limit       = RST_CHUNK_LIMIT;
    close_frame();
    slot_ready = '0;
    wr_pos     = '0;
    rd_pos     = '0;
    ready_cnt  = '0;
  endtask

  // Advance the shadow by one accepted transaction and queue its result.
  task automatic reassembly_step(input crr_op_e op, input crr_hdr_t h);
    frame_result_t r;
    logic [47:0]   offs;
    r.status = ST_WRITTEN;
    r.res    = '0;
    if (op == OP_POP) begin
      if (ready_cnt == 0 || !slot_ready[rd_pos]) begin
        r.status = ST_POP_EMPTY;
      end else begin
        slot_ready[rd_pos] = 1'b0;
        rd_pos    = rd_pos + 1'b1;
        ready_cnt = ready_cnt - 1'b1;
        r.status  = ST_POPPED;
      end
    end else if (h.packet_length < HEADER_BYTES) begin
      r.status = ST_SHORT;
    end else if (h.magic != cfg_magic || h.kind != cfg_kind) begin
      r.status = ST_BAD_MAGIC;
    end else if (h.chunk_total == 0 || h.chunk_total >= cfg_limit) begin
      r.status = ST_BAD_TOTAL;
    end else if (!frame_open && ready_cnt >= RING_SLOTS) begin
      r.status = ST_RING_FULL;
    end else begin
      // a different frame id abandons whatever was being assembled
      if (!frame_open || h.frame_id != open_id) begin
        close_frame();
        frame_open = 1'b1;
        open_id    = h.frame_id;
        exp_chunks = h.chunk_total;
      end
      offs = 48'(h.chunk_index) * 48'(cfg_chunk_bytes);
      if (h.chunk_index < exp_chunks && h.chunk_index < MAP_BITS &&
          offs + 48'(h.payload_length) <= 48'(cfg_frame_bytes)) begin
        r.status           = ST_WRITTEN;
        r.res.write_enable = 1'b1;
        r.res.write_slot   = wr_pos;
        r.res.write_offset = offs[24:0];
        r.res.write_length = h.payload_length;
        if (!seen_map[h.chunk_index[9:0]]) begin
          seen_map[h.chunk_index[9:0]] = 1'b1;
          got_chunks = got_chunks + 1'b1;
        end
        if (got_chunks == exp_chunks) begin
          slot_ready[wr_pos] = 1'b1;
          ready_cnt = ready_cnt + 1'b1;
          wr_pos    = wr_pos + 1'b1;
          close_frame();
          r.res.frame_done = 1'b1;
        end
      end else begin
        r.status = ST_OUTSIDE;
      end
    end
    r.res.head_valid   = (ready_cnt != 0) && slot_ready[rd_pos];
    r.res.head_slot    = rd_pos;
    r.res.frames_ready = ready_cnt;
    pending_results.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s expected %0h actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    frame_result_t want;
    crr_res_t      got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = crr_res_t'(m_axis_tdata);
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result expected none actual status %0d data %0h",
                 $time, m_axis_tuser, m_axis_tdata);
        fails++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", 32'(want.status), 32'(m_axis_tuser));
        compare_field("write_enable", 32'(want.res.write_enable), 32'(got.write_enable));
        compare_field("write_slot", 32'(want.res.write_slot), 32'(got.write_slot));
        compare_field("write_offset", 32'(want.res.write_offset), 32'(got.write_offset));
        compare_field("write_length", 32'(want.res.write_length), 32'(got.write_length));
        compare_field("frame_done", 32'(want.res.frame_done), 32'(got.frame_done));
        compare_field("head_valid", 32'(want.res.head_valid), 32'(got.head_valid));
        compare_field("head_slot", 32'(want.res.head_slot), 32'(got.head_slot));
        compare_field("frames_ready", 32'(want.res.frames_ready), 32'(got.frames_ready));
        compare_field("pad", 32'(want.res.pad), 32'(got.pad));
      end
    end
  end

  // Result side: random stalls, or one long hold-off on request.
  initial begin : rx_side
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_rx_req) begin
        hold_rx_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk_i);
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 31);
      end
    end
  end

  task automatic send_item(input crr_op_e op, input crr_hdr_t h);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= h;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk_i);
    reassembly_step(op, h);
  endtask

  // Lowers valid, then waits for every outstanding result.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input crr_cfg_idx_e idx, input logic [24:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_MAGIC_WORD:  cfg_magic       = val[15:0];
      CFG_INPUT_KIND:  cfg_kind        = val[15:0];
      CFG_CHUNK_BYTES: cfg_chunk_bytes = val[15:0];
      CFG_FRAME_BYTES: cfg_frame_bytes = val;
      CFG_CHUNK_LIMIT: cfg_limit       = val[10:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_config(input logic [15:0] magic, input logic [15:0] kind,
                              input logic [15:0] cb, input logic [24:0] fb,
                              input logic [10:0] lim);
    wait_idle();
    write_reg(CFG_MAGIC_WORD, 25'(magic));
    write_reg(CFG_INPUT_KIND, 25'(kind));
    write_reg(CFG_CHUNK_BYTES, 25'(cb));
    write_reg(CFG_FRAME_BYTES, fb);
    write_reg(CFG_CHUNK_LIMIT, 25'(lim));
  endtask

  function automatic crr_hdr_t random_hdr();
    return crr_hdr_t'({$urandom, $urandom, $urandom, $urandom});
  endfunction

  // Valid header whose payload fits the slot unless the offset alone overruns it.
  function automatic crr_hdr_t good_hdr(input logic [31:0] fid, input int cid, input int total);
    crr_hdr_t        h;
    longint unsigned offs;
    longint unsigned cap;
    h.packet_length = $urandom_range(HEADER_BYTES, 16'hFFFF);
    h.magic         = cfg_magic;
    h.kind          = cfg_kind;
    h.frame_id      = fid;
    h.chunk_index   = cid;
    h.chunk_total   = total;
    offs = longint'(cid) * cfg_chunk_bytes;
    if (offs > cfg_frame_bytes) begin
      h.payload_length = $urandom_range(0, 16'hFFFF);
    end else begin
      cap = cfg_frame_bytes - offs;
      if (cap > 65535) cap = 65535;
      if ($urandom_range(0, 3) != 0 && cap > cfg_chunk_bytes) cap = cfg_chunk_bytes;
      h.payload_length = $urandom_range(0, int'(cap));
    end
    return h;
  endfunction

  function automatic crr_hdr_t noisy_hdr();
    crr_hdr_t h;
    h = good_hdr($urandom, $urandom_range(0, 7), $urandom_range(1, 8));
    case ($urandom_range(0, 4))
      0: h = random_hdr();
      1: h.packet_length = $urandom_range(0, HEADER_BYTES - 1);
      2: begin
        if ($urandom_range(0, 1)) h.magic = h.magic ^ (16'd1 << $urandom_range(0, 15));
        else h.kind = h.kind ^ (16'd1 << $urandom_range(0, 15));
      end
      3: h.chunk_total = $urandom_range(0, 1) ? 16'd0 : $urandom_range(cfg_limit, 16'hFFFF);
      default: begin
        h.chunk_index = $urandom_range(0, 16'hFFFF);
        h.chunk_total = $urandom_range(1, cfg_limit > 1 ? cfg_limit - 1 : 1);
      end
    endcase
    return h;
  endfunction

  // Mostly whole frames with chunks in random order, duplicates and pops mixed in,
  // plus malformed headers and abandoned frames.
  task automatic run_traffic(input int n_items);
    int          sent;
    int          total;
    int          max_total;
    int          k;
    int          j;
    int          tmp;
    int          order[8];
    logic [31:0] fid;
    sent      = 0;
    max_total = 8;
    if (int'(cfg_limit) - 1 < max_total) max_total = int'(cfg_limit) - 1;
    if (int'(cfg_frame_bytes) / int'(cfg_chunk_bytes) < max_total)
      max_total = int'(cfg_frame_bytes) / int'(cfg_chunk_bytes);
    if (max_total < 1) max_total = 1;
    while (sent < n_items) begin
      k = $urandom_range(0, 99);
      if (k < 12) begin
        send_item(OP_POP, random_hdr());
        sent++;
      end else if (k < 30) begin
        send_item(OP_HEADER, noisy_hdr());
        sent++;
      end else begin
        fid   = $urandom;
        total = $urandom_range(1, max_total);
        for (k = 0; k < total; k++) order[k] = k;
        for (k = total - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
        for (k = 0; k < total; k++) begin
          if ($urandom_range(0, 99) < 4) break;
          if ($urandom_range(0, 99) < 12) begin
            send_item(OP_POP, random_hdr());
            sent++;
          end
          send_item(OP_HEADER, good_hdr(fid, order[k], total));
          sent++;
          if ($urandom_range(0, 99) < 10) begin
            send_item(OP_HEADER, good_hdr(fid, order[$urandom_range(0, k)], total));
            sent++;
          end
        end
      end
    end
  endtask

  task automatic test_directed();
    crr_hdr_t h;
    send_item(OP_POP, random_hdr());
    h = good_hdr(NO_FRAME, 0, 2);
    h.packet_length = 16'd0;
    send_item(OP_HEADER, h);
    h.packet_length = HEADER_BYTES - 1;
    send_item(OP_HEADER, h);
    h = good_hdr(NO_FRAME, 0, 2);
    h.magic = ~cfg_magic;
    send_item(OP_HEADER, h);
    h = good_hdr(NO_FRAME, 0, 2);
    h.kind = cfg_kind ^ 16'h8000;
    send_item(OP_HEADER, h);
    h = good_hdr(NO_FRAME, 0, 2);
    h.chunk_total = 16'd0;
    send_item(OP_HEADER, h);
    h.chunk_total = 16'(cfg_limit);
    send_item(OP_HEADER, h);
    h.chunk_total = 16'hFFFF;
    send_item(OP_HEADER, h);
    // all-ones frame id is an ordinary frame; duplicate counted once
    h = good_hdr(NO_FRAME, 0, 2);
    h.packet_length = HEADER_BYTES;
    send_item(OP_HEADER, h);
    send_item(OP_HEADER, h);
    send_item(OP_HEADER, good_hdr(NO_FRAME, 5, 2));
    send_item(OP_HEADER, good_hdr(NO_FRAME, 1, 2));
    send_item(OP_POP, random_hdr());
    send_item(OP_POP, random_hdr());
    // frame id change restarts assembly in the same slot
    send_item(OP_HEADER, good_hdr(32'd0, 0, 3));
    send_item(OP_HEADER, good_hdr(32'd0, 2, 3));
    send_item(OP_HEADER, good_hdr(32'd1, 0, 1));
    h = good_hdr(32'd2, 698, 699);
    h.payload_length = 16'hFFFF;
    send_item(OP_HEADER, h);
    send_item(OP_HEADER, good_hdr(32'd2, 16'hFFFF, 699));
    send_item(OP_HEADER, good_hdr(32'd2, 0, 699));
    send_item(OP_POP, random_hdr());
    send_item(OP_POP, random_hdr());
  endtask

  task automatic test_ring_full();
    int n;
    while (ready_cnt < RING_SLOTS) send_item(OP_HEADER, good_hdr($urandom, 0, 1));
    for (n = 0; n < 3; n++) send_item(OP_HEADER, good_hdr($urandom, $urandom_range(0, 1), 2));
    send_item(OP_POP, random_hdr());
    send_item(OP_HEADER, good_hdr(32'hCAFE_0001, 0, 2));
    send_item(OP_HEADER, good_hdr(32'hCAFE_0002, 1, 2));
    while (ready_cnt != 0) begin
      if ($urandom_range(0, 9) == 0) send_item(OP_HEADER, noisy_hdr());
      send_item(OP_POP, random_hdr());
    end
    send_item(OP_POP, random_hdr());
  endtask

  task automatic test_config_extremes();
    crr_hdr_t h;
    wait_idle();
    write_reg(CFG_CHUNK_LIMIT, 25'd1);
    send_item(OP_HEADER, good_hdr($urandom, 0, 1));
    wait_idle();
    write_reg(CFG_CHUNK_LIMIT, 25'd1024);
    write_reg(CFG_CHUNK_BYTES, 25'hFFFF);
    write_reg(CFG_FRAME_BYTES, 25'd16777216);
    h = good_hdr(32'h1234_5678, 255, 1023);
    h.payload_length = 16'hFFFF;
    send_item(OP_HEADER, h);
    h = good_hdr(32'h1234_5678, 256, 1023);
    h.payload_length = 16'hFFFF;
    send_item(OP_HEADER, h);
    send_item(OP_HEADER, good_hdr(32'h1234_5678, 1022, 1023));
    wait_idle();
    write_reg(CFG_MAGIC_WORD, 25'd0);
    write_reg(CFG_INPUT_KIND, 25'd0);
    write_reg(CFG_CHUNK_BYTES, 25'd1);
    write_reg(CFG_FRAME_BYTES, 25'd1);
    h = good_hdr(32'd7, 1, 2);
    h.payload_length = 16'd0;
    send_item(OP_HEADER, h);
    h = good_hdr(32'd7, 0, 2);
    h.payload_length = 16'd1;
    send_item(OP_HEADER, h);
    wait_idle();
    write_reg(CFG_MAGIC_WORD, 25'hFFFF);
    write_reg(CFG_INPUT_KIND, 25'hFFFF);
    send_item(OP_HEADER, good_hdr($urandom, 0, 1));
    send_item(OP_POP, random_hdr());
    write_config(RST_MAGIC_WORD, RST_INPUT_KIND, RST_CHUNK_BYTES, RST_FRAME_BYTES,
                 RST_CHUNK_LIMIT);
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_rx_req = 1'b1;
    run_traffic(60);
    // sender stops until every outstanding result has drained
    wait_idle();
  endtask

  task automatic test_no_idle_burst();
    wait_idle();
    no_idle = 1'b1;
    run_traffic(250);
    wait_idle();
    no_idle = 1'b0;
  endtask

  task automatic test_random_settings();
    int          p;
    logic [15:0] cb;
    logic [24:0] fb;
    logic [10:0] lim;
    for (p = 0; p < 5; p++) begin
      case ($urandom_range(0, 3))
        0: cb = 16'd1;
        1: cb = 16'hFFFF;
        2: cb = RST_CHUNK_BYTES;
        default: cb = $urandom_range(1, 16'hFFFF);
      endcase
      case ($urandom_range(0, 3))
        0: fb = 25'd1;
        1: fb = 25'd16777216;
        2: fb = RST_FRAME_BYTES;
        default: fb = $urandom_range(1, 16777216);
      endcase
      case ($urandom_range(0, 3))
        0: lim = 11'd2;
        1: lim = 11'd1024;
        2: lim = RST_CHUNK_LIMIT;
        default: lim = $urandom_range(2, 1024);
      endcase
      write_config($urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF), cb, fb, lim);
      run_traffic(150);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_MAGIC_WORD;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_HEADER;
    fails         = 0;
    no_idle       = 1'b0;
    hold_rx_req   = 1'b0;
    model_reset();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_ring_full();
    test_config_extremes();
    test_backpressure();
    test_no_idle_burst();
    test_random_settings();

    wait_idle();
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/crr_pkg.sv
hdl/crr_ram.sv
hdl/chunk_reassembly_ring_unit.sv
tb/chunk_reassembly_ring_unit_tb.sv
